// ----- rtl/tls_pkg.sv -----
// package for the three level task scheduler
// shared types, status and opcode codes; no dependencies
package tls_pkg;
    localparam int STACK_DEPTH = 8;
    localparam int RING_SLOTS  = 8;
    localparam int LIST_DEPTH  = 32;
    localparam int SW = $clog2(STACK_DEPTH + 1);
    localparam int RW = (RING_SLOTS > 2) ? $clog2(RING_SLOTS) : 1;
    localparam int LW = $clog2(LIST_DEPTH + 1);
    localparam int QDEPTH = 2;

    typedef enum logic [2:0] {
        OP_PUSH = 3'd0, OP_ENQ = 3'd1, OP_INS = 3'd2, OP_PROC = 3'd3, OP_PROM = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_FULL = 3'd1, ST_EMPTY = 3'd2, ST_NOTFOUND = 3'd3, ST_DROPPED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        SRC_STACK = 2'd0, SRC_FIFO = 2'd1, SRC_LIST = 2'd2
    } src_t;

    typedef struct packed {
        logic [15:0] id;
        logic [3:0]  pri;
    } entry_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic       known;
        entry_t     t;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        served_valid;
        logic [15:0] served_id;
        logic [3:0]  served_priority;
        logic [1:0]  served_source;
    } result_t;

    typedef enum logic [1:0] {S_IDLE, S_PROM, S_OUT} state_t;
endpackage

// ----- rtl/tls_front.sv -----
// front: accepts and classifies requests into a two-entry command queue
// depends on tls_pkg
module tls_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [2:0]     in_op,
    input  logic [15:0]    in_id,
    input  logic [3:0]     in_pri,
    output logic           q_valid,
    input  logic           q_ready,
    output tls_pkg::cmd_t  q_cmd
);
    tls_pkg::cmd_t q_reg [tls_pkg::QDEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    tls_pkg::cmd_t c;
    logic push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = q_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        c.opcode = in_op;
        c.known  = (in_op <= tls_pkg::OP_PROM);
        c.t.id   = in_id;
        c.t.pri  = in_pri;
    end

    always_ff @(posedge aclk) begin
        if (push) q_reg[wp_reg] <= c;
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ----- rtl/tls_back.sv -----
// back: executes commands on stack, ring and sorted cell chain
// depends on tls_pkg
module tls_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    output logic             q_ready,
    input  tls_pkg::cmd_t    q_cmd,
    output logic             m_valid,
    input  logic             m_ready,
    output tls_pkg::result_t m_res
);
    localparam int SD = tls_pkg::STACK_DEPTH;
    localparam int RS = tls_pkg::RING_SLOTS;
    localparam int LD = tls_pkg::LIST_DEPTH;
    localparam int SW = tls_pkg::SW;
    localparam int RW = tls_pkg::RW;
    localparam int LW = tls_pkg::LW;
    localparam int SIW = (SD > 1) ? $clog2(SD) : 1;

    tls_pkg::entry_t stk_reg [SD];
    tls_pkg::entry_t ring_reg [RS];
    tls_pkg::entry_t lst_reg [LD];
    logic [SW-1:0] scnt_reg;
    logic [RW-1:0] head_reg, tail_reg;
    logic [LW-1:0] lcnt_reg;
    tls_pkg::state_t state_reg, state_next;
    tls_pkg::result_t res_reg;
    tls_pkg::cmd_t cmd_reg;

    logic [LD-1:0] match_reg;
    logic [LD-1:0] gt, gt_dn, hit, prior;
    logic found;
    tls_pkg::entry_t hit_e;
    logic [RW-1:0] tail_inc, head_inc;
    logic ring_full, take, stack_full, list_full;
    logic [SIW-1:0] sidx_top, sidx_w;

    function automatic logic [RW-1:0] rnext(input logic [RW-1:0] p);
        rnext = (p == RW'(RS - 1)) ? '0 : p + RW'(1);
    endfunction

    function automatic tls_pkg::result_t mk_res(input logic [2:0] st, input logic v,
                                                input tls_pkg::entry_t e,
                                                input logic [1:0] src);
        mk_res.status          = st;
        mk_res.served_valid    = v;
        mk_res.served_id       = e.id;
        mk_res.served_priority = e.pri;
        mk_res.served_source   = src;
    endfunction

    assign tail_inc   = rnext(tail_reg);
    assign head_inc   = rnext(head_reg);
    assign ring_full  = (tail_inc == head_reg);
    assign stack_full = (scnt_reg >= SW'(SD));
    assign list_full  = (lcnt_reg >= LW'(LD));
    assign sidx_top   = SIW'(scnt_reg - SW'(1));
    assign sidx_w     = SIW'(scnt_reg);
    assign take       = q_valid && q_ready;
    assign q_ready    = (state_reg == tls_pkg::S_IDLE);
    assign m_valid    = (state_reg == tls_pkg::S_OUT);
    assign m_res      = res_reg;

    always_comb begin
        for (int k = 0; k < LD; k++) begin
            gt[k]  = (LW'(k) < lcnt_reg) && (lst_reg[k].pri > cmd_reg.t.pri);
            hit[k] = match_reg[k];
        end
        gt_dn[0] = 1'b0;
        for (int k = 1; k < LD; k++) gt_dn[k] = gt[k-1];
        prior[0] = 1'b0;
        for (int k = 1; k < LD; k++) prior[k] = prior[k-1] | hit[k-1];
        found = |hit;
        hit_e = '0;
        for (int k = LD - 1; k >= 0; k--) begin
            if (hit[k]) hit_e = lst_reg[k];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tls_pkg::S_IDLE: if (take) begin
                if (q_cmd.opcode == tls_pkg::OP_PROM ||
                    (q_cmd.opcode == tls_pkg::OP_INS && !list_full))
                    state_next = tls_pkg::S_PROM;
                else
                    state_next = tls_pkg::S_OUT;
            end
            tls_pkg::S_PROM: state_next = tls_pkg::S_OUT;
            tls_pkg::S_OUT:  if (m_ready) state_next = tls_pkg::S_IDLE;
            default:         state_next = tls_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tls_pkg::S_IDLE;
            scnt_reg <= '0; head_reg <= '0; tail_reg <= '0; lcnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (take) begin
                cmd_reg <= q_cmd;
                for (int k = 0; k < LD; k++)
                    match_reg[k] <= (LW'(k) < lcnt_reg) && (lst_reg[k].id == q_cmd.t.id);
                case (q_cmd.opcode)
                    tls_pkg::OP_PUSH: begin
                        res_reg <= mk_res(stack_full ? tls_pkg::ST_FULL : tls_pkg::ST_OK,
                                          1'b0, '0, tls_pkg::SRC_STACK);
                        if (!stack_full) begin
                            stk_reg[sidx_w] <= q_cmd.t;
                            scnt_reg <= scnt_reg + SW'(1);
                        end
                    end
                    tls_pkg::OP_ENQ: begin
                        res_reg <= mk_res(ring_full ? tls_pkg::ST_FULL : tls_pkg::ST_OK,
                                          1'b0, '0, tls_pkg::SRC_STACK);
                        if (!ring_full) begin
                            ring_reg[tail_reg] <= q_cmd.t;
                            tail_reg <= tail_inc;
                        end
                    end
                    tls_pkg::OP_INS: begin
                        res_reg <= mk_res(list_full ? tls_pkg::ST_FULL : tls_pkg::ST_OK,
                                          1'b0, '0, tls_pkg::SRC_STACK);
                    end
                    tls_pkg::OP_PROC: begin
                        if (scnt_reg != '0) begin
                            scnt_reg <= scnt_reg - SW'(1);
                            res_reg <= mk_res(tls_pkg::ST_OK, 1'b1, stk_reg[sidx_top],
                                              tls_pkg::SRC_STACK);
                        end else if (head_reg != tail_reg) begin
                            head_reg <= head_inc;
                            res_reg <= mk_res(tls_pkg::ST_OK, 1'b1, ring_reg[head_reg],
                                              tls_pkg::SRC_FIFO);
                        end else if (lcnt_reg != '0) begin
                            for (int k = 0; k < LD - 1; k++) lst_reg[k] <= lst_reg[k+1];
                            lcnt_reg <= lcnt_reg - LW'(1);
                            res_reg <= mk_res(tls_pkg::ST_OK, 1'b1, lst_reg[0],
                                              tls_pkg::SRC_LIST);
                        end else begin
                            res_reg <= mk_res(tls_pkg::ST_EMPTY, 1'b0, '0,
                                              tls_pkg::SRC_STACK);
                        end
                    end
                    default: res_reg <= '0;
                endcase
            end
            if (state_reg == tls_pkg::S_PROM) begin
                if (cmd_reg.opcode == tls_pkg::OP_INS) begin
                    // cell chain: entries above the slot shift up by one
                    for (int k = 0; k < LD; k++) begin
                        if (gt_dn[k]) lst_reg[k] <= lst_reg[(k + LD - 1) % LD];
                        else if (gt[k] || LW'(k) == lcnt_reg) lst_reg[k] <= cmd_reg.t;
                    end
                    lcnt_reg <= lcnt_reg + LW'(1);
                end else begin
                    if (!found) res_reg.status <= tls_pkg::ST_NOTFOUND;
                    else begin
                        for (int k = 0; k < LD - 1; k++)
                            if (prior[k+1] || hit[k]) lst_reg[k] <= lst_reg[k+1];
                        lcnt_reg <= lcnt_reg - LW'(1);
                        if (stack_full) res_reg.status <= tls_pkg::ST_DROPPED;
                        else begin
                            stk_reg[sidx_w] <= hit_e;
                            scnt_reg <= scnt_reg + SW'(1);
                        end
                    end
                end
            end
        end
    end

    logic unused;
    assign unused = cmd_reg.known;
endmodule

// ----- rtl/three_level_task_scheduler_core.sv -----
// Three level task scheduler: emergency stack, periodic ring and a sorted
// background list. Each request yields one result. The back end takes a request
// while idle, passes through the promote state for a non-full insert and for
// promote, which use the sorted cell chain, and then holds the result until the
// handshake; a result held by m_tready stalls it. The front queue holds two
// requests so the input can still accept up to two requests while a result waits.
// depends on tls_pkg, tls_front, tls_back
module three_level_task_scheduler_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // opcode[2:0], task_id[18:3], priority_req[22:19]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata   // status, served_valid, served_id, served_priority,
                                  // served_source
);
    logic q_valid, q_ready;
    tls_pkg::cmd_t q_cmd;
    tls_pkg::result_t res;

    tls_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_op(s_tdata[2:0]), .in_id(s_tdata[18:3]), .in_pri(s_tdata[22:19]),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    tls_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_res(res)
    );

    assign m_tdata = {6'd0, res.served_source, res.served_priority, res.served_id,
                      res.served_valid, res.status};

    logic unused;
    assign unused = s_tdata[23];
endmodule

// ----- bench/three_level_task_scheduler_core_tb.sv -----
// testbench for three_level_task_scheduler_core: random and directed scheduler requests,
// results checked against a behavioral scheduler model kept in a small scoreboard class
// depends on tls_pkg and the core rtl
`timescale 1ns / 1ps
module three_level_task_scheduler_core_tb;

    class sched_scoreboard;
        tls_pkg::entry_t stack_q[$];
        tls_pkg::entry_t ring_q[$];
        tls_pkg::entry_t list_q[$];
        tls_pkg::result_t pending[$];
        int mismatches;
        int checked;
        int served_cnt[3];
        int status_cnt[5];

        function void note_request(logic [2:0] op, logic [15:0] id, logic [3:0] pri);
            tls_pkg::result_t r;
            tls_pkg::entry_t e;
            int k;
            r = '0;
            e.id = id;
            e.pri = pri;
            case (op)
                tls_pkg::OP_PUSH: begin
                    if (stack_q.size() >= tls_pkg::STACK_DEPTH) r.status = tls_pkg::ST_FULL;
                    else stack_q.push_back(e);
                end
                tls_pkg::OP_ENQ: begin
                    if (ring_q.size() >= tls_pkg::RING_SLOTS - 1) r.status = tls_pkg::ST_FULL;
                    else ring_q.push_back(e);
                end
                tls_pkg::OP_INS: begin
                    if (list_q.size() >= tls_pkg::LIST_DEPTH) begin
                        r.status = tls_pkg::ST_FULL;
                    end else begin
                        k = list_q.size();
                        while (k > 0 && list_q[k-1].pri > pri) k--;
                        list_q.insert(k, e);
                    end
                end
                tls_pkg::OP_PROC: begin
                    r.served_valid = 1'b1;
                    if (stack_q.size() > 0) begin
                        e = stack_q.pop_back();
                        r.served_source = tls_pkg::SRC_STACK;
                    end else if (ring_q.size() > 0) begin
                        e = ring_q.pop_front();
                        r.served_source = tls_pkg::SRC_FIFO;
                    end else if (list_q.size() > 0) begin
                        e = list_q.pop_front();
                        r.served_source = tls_pkg::SRC_LIST;
                    end else begin
                        r.served_valid = 1'b0;
                        r.status = tls_pkg::ST_EMPTY;
                    end
                    if (r.served_valid) begin
                        r.served_id = e.id;
                        r.served_priority = e.pri;
                        served_cnt[r.served_source]++;
                    end
                end
                tls_pkg::OP_PROM: begin
                    r.status = tls_pkg::ST_NOTFOUND;
                    for (k = 0; k < list_q.size(); k++) begin
                        if (list_q[k].id == id) begin
                            e = list_q[k];
                            list_q.delete(k);
                            if (stack_q.size() >= tls_pkg::STACK_DEPTH) begin
                                r.status = tls_pkg::ST_DROPPED;
                            end else begin
                                stack_q.push_back(e);
                                r.status = tls_pkg::ST_OK;
                            end
                            break;
                        end
                    end
                end
                default: ;
            endcase
            status_cnt[r.status]++;
            pending.push_back(r);
        endfunction

        function void check_result(logic [31:0] data);
            tls_pkg::result_t got;
            tls_pkg::result_t want;
            got.status          = data[2:0];
            got.served_valid    = data[3];
            got.served_id       = data[19:4];
            got.served_priority = data[23:20];
            got.served_source   = data[25:24];
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transaction %h", data);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status || got.served_valid !== want.served_valid
                    || got.served_id !== want.served_id
                    || got.served_priority !== want.served_priority
                    || got.served_source !== want.served_source) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result %0d: expected st=%0d v=%0d id=%h pri=%0d src=%0d,",
                              " got st=%0d v=%0d id=%h pri=%0d src=%0d"},
                        checked, want.status, want.served_valid, want.served_id,
                        want.served_priority, want.served_source, got.status,
                        got.served_valid, got.served_id, got.served_priority,
                        got.served_source);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // opcode[2:0], task_id[18:3], priority_req[22:19]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // served_source, served_priority, served_id, served_valid, status

    sched_scoreboard sb;
    int  sent;
    int  idle_cycles;
    bit  calm;
    bit  hold_off;
    logic [15:0] recent_ids[$];

    three_level_task_scheduler_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    task automatic send_request(logic [2:0] op, logic [15:0] id, logic [3:0] pri);
        while (!calm && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, pri, id, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(op, id, pri);
        sent++;
        if (op == tls_pkg::OP_INS) begin
            recent_ids.push_back(id);
            if (recent_ids.size() > 40) void'(recent_ids.pop_front());
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    task automatic random_request();
        logic [2:0]  op;
        logic [15:0] id;
        int pick;
        pick = $urandom_range(99);
        id = 16'($urandom);
        if (pick < 18) op = tls_pkg::OP_PUSH;
        else if (pick < 36) op = tls_pkg::OP_ENQ;
        else if (pick < 60) op = tls_pkg::OP_INS;
        else if (pick < 88) op = tls_pkg::OP_PROC;
        else if (pick < 97) op = tls_pkg::OP_PROM;
        else op = 3'($urandom_range(5, 7));
        if (op == tls_pkg::OP_PROM && recent_ids.size() > 0 && $urandom_range(3) != 0)
            id = recent_ids[$urandom_range(recent_ids.size() - 1)];
        send_request(op, id, 4'($urandom));
    endtask

    // result side with random stalls and one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            m_tready <= !hold_off && (calm || $urandom_range(99) >= 34);
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int i;
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        calm = 1'b0;
        hold_off = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty, extremes, full stores, promote cases, unused opcodes
        send_request(tls_pkg::OP_PROC, 16'h0000, 4'h0);
        send_request(tls_pkg::OP_PROM, 16'hffff, 4'hf);
        for (i = 0; i < 9; i++) send_request(tls_pkg::OP_PUSH, 16'hffff - 16'(i), 4'hf);
        for (i = 0; i < 8; i++) send_request(tls_pkg::OP_ENQ, 16'(i), 4'(i));
        send_request(tls_pkg::OP_INS, 16'h0000, 4'h0);
        send_request(tls_pkg::OP_INS, 16'hffff, 4'hf);
        send_request(tls_pkg::OP_PROM, 16'hffff, 4'h0);
        send_request(3'd5, 16'h1234, 4'h5);
        send_request(3'd7, 16'hffff, 4'hf);
        wait_drained();

        // drain, then fill the list past full with priority ties
        for (i = 0; i < 20; i++) send_request(tls_pkg::OP_PROC, 16'h0, 4'h0);
        for (i = 0; i < 34; i++)
            send_request(tls_pkg::OP_INS, 16'(16'h100 + i), 4'($urandom_range(3)));
        for (i = 0; i < 4; i++) send_request(tls_pkg::OP_PROM, 16'(16'h100 + i * 5), 4'h0);
        for (i = 0; i < 40; i++) send_request(tls_pkg::OP_PROC, 16'h0, 4'h0);
        wait_drained();

        // receiver holds off while requests keep coming
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (i = 0; i < 30; i++) random_request();
        join
        wait_drained();

        for (i = 0; i < 1500; i++) begin
            calm = (i >= 600 && i < 800);
            random_request();
            if (i == 1000) wait_drained();
        end
        calm = 1'b0;
        wait_drained();
        repeat (20) @(posedge aclk);

        $display("sent %0d requests, checked %0d results; served stack/fifo/list %0d/%0d/%0d",
            sent, sb.checked, sb.served_cnt[0], sb.served_cnt[1], sb.served_cnt[2]);
        $display("status ok/full/empty/notfound/dropped %0d/%0d/%0d/%0d/%0d",
            sb.status_cnt[0], sb.status_cnt[1], sb.status_cnt[2], sb.status_cnt[3],
            sb.status_cnt[4]);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
